>>> rtl/b3264enc_pkg.sv
// ----------------------------------------------------------------------------
// b3264enc_pkg: shared types and constants for the base32/base64 encoder
// Word types for both queue sides, the front-to-back command, register
// indexes and the digit-to-ASCII mapping for the three alphabets.
// ----------------------------------------------------------------------------
package b3264enc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgIdxMode  = 2'd0;
  localparam logic [1:0] CfgIdxNoPad = 2'd1;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 2;

  // Mode register: bit 1 selects base64, bit 0 selects base32hex when bit 1 is clear
  localparam int unsigned ModeB64Bit = 1;
  localparam int unsigned ModeHexBit = 0;

  // Depth of the command queue between front and back (2 or more)
  localparam int unsigned CmdQueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;  // '='

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_word_t;

  // One byte's worth of work for the back end
  typedef struct packed {
    logic [2:0][7:0] chars;  // up to three encoded characters
    logic [1:0]      nchar;  // 1..3 characters from chars
    logic [2:0]      npad;   // '=' characters that follow
    logic            last;   // final word of the message
  } cmd_t;

  // Map a digit to its ASCII character in the selected alphabet
  function automatic logic [7:0] digit_char(logic [1:0] mode, logic [5:0] d);
    logic [4:0] d5;
    logic [7:0] ch;
    d5 = d[4:0];
    if (mode[ModeB64Bit]) begin
      if (d < 6'd26)      ch = 8'h41 + {2'b00, d};
      else if (d < 6'd52) ch = 8'h61 + {2'b00, d - 6'd26};
      else if (d < 6'd62) ch = 8'h30 + {2'b00, d - 6'd52};
      else if (d == 6'd62) ch = 8'h2B;
      else                ch = 8'h2F;
    end else if (mode[ModeHexBit]) begin
      if (d5 < 5'd10) ch = 8'h30 + {3'b000, d5};
      else            ch = 8'h41 + {3'b000, d5 - 5'd10};
    end else begin
      if (d5 < 5'd26) ch = 8'h41 + {3'b000, d5};
      else            ch = 8'h32 + {3'b000, d5 - 5'd26};
    end
    return ch;
  endfunction

endpackage

>>> rtl/b3264enc_front.sv
// ----------------------------------------------------------------------------
// b3264enc_front: input side of the encoder
// Holds the configuration and the bit-packing state, splits each byte into
// digits, works out the flush digit and padding, and pushes one command.
// ----------------------------------------------------------------------------
module b3264enc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  input  logic [b3264enc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [b3264enc_pkg::CfgDataW-1:0]   cfg_data_i,
  // input word
  input  logic                                push_i,
  input  b3264enc_pkg::in_word_t              in_i,
  // command queue side
  input  logic                                q_full_i,
  output logic                                cmd_push_o,
  output b3264enc_pkg::cmd_t                  cmd_o
);
  import b3264enc_pkg::*;

  logic [1:0]  mode_q, mode_d;
  logic        no_pad_q, no_pad_d;
  logic [3:0]  bits_q, bits_d;
  logic [2:0]  count_q, count_d;
  logic [2:0]  gp_q, gp_d;

  logic        b64;
  logic [2:0]  w;
  logic [5:0]  mask;
  logic [2:0]  cnt;
  logic [11:0] acc;
  logic [3:0]  nbits, sh1, sh2, rem;
  logic        two;
  logic [5:0]  d0, d1, dp;
  logic [16:0] part_wide;
  logic        has_part;
  logic [1:0]  nchar;
  logic [3:0]  gp_sum;
  logic [2:0]  gp_after;
  logic [3:0]  grp, pad_raw, pad_room, pad;
  logic [11:0] lo_mask;
  logic        accept;

  assign accept     = push_i & ~q_full_i;
  assign cmd_push_o = accept;

  // Digit split of the current byte
  always_comb begin
    b64  = mode_q[ModeB64Bit];
    w    = b64 ? 3'd6 : 3'd5;
    mask = b64 ? 6'h3F : 6'h1F;
    grp  = b64 ? 4'd4 : 4'd8;
    cnt  = (count_q > 3'd4) ? 3'd4 : count_q;
    acc  = {bits_q, in_i.data_byte};
    nbits = {1'b0, cnt} + 4'd8;
    two  = nbits >= {w, 1'b0};
    sh1  = nbits - {1'b0, w};
    sh2  = sh1 - {1'b0, w};
    d0   = 6'(acc >> sh1) & mask;
    d1   = 6'(acc >> sh2) & mask;
    rem  = two ? sh2 : sh1;
    part_wide = {5'b00000, acc} << (w - rem[2:0]);
    dp   = part_wide[5:0] & mask;
    has_part = in_i.last_byte & (rem != 4'd0);
    nchar = (two ? 2'd2 : 2'd1) + {1'b0, has_part};

    // group position after this byte's characters
    gp_sum   = {1'b0, gp_q} + {2'b00, nchar};
    gp_after = b64 ? {1'b0, gp_sum[1:0]} : gp_sum[2:0];
    pad_raw  = (gp_after == 3'd0) ? 4'd0 : grp - {1'b0, gp_after};
    pad_room = 4'd8 - {2'b00, nchar};
    pad      = (pad_raw > pad_room) ? pad_room : pad_raw;
    lo_mask  = ~(12'hFFF << rem);
  end

  // Command for the back end
  always_comb begin
    cmd_o.chars[0] = digit_char(mode_q, d0);
    cmd_o.chars[1] = two ? digit_char(mode_q, d1) : digit_char(mode_q, dp);
    cmd_o.chars[2] = digit_char(mode_q, dp);
    cmd_o.nchar    = nchar;
    cmd_o.npad     = (in_i.last_byte & ~no_pad_q) ? pad[2:0] : 3'd0;
    cmd_o.last     = in_i.last_byte;
  end

  // Next state: a config write takes priority over the stream update on accept
  always_comb begin
    mode_d   = mode_q;
    no_pad_d = no_pad_q;
    bits_d   = bits_q;
    count_d  = count_q;
    gp_d     = gp_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxMode) begin
        mode_d  = cfg_data_i[1:0];
        bits_d  = 4'd0;
        count_d = 3'd0;
        gp_d    = 3'd0;
      end else if (cfg_index_i == CfgIdxNoPad) begin
        no_pad_d = cfg_data_i[0];
      end
    end else if (accept) begin
      if (in_i.last_byte) begin
        bits_d  = 4'd0;
        count_d = 3'd0;
        gp_d    = 3'd0;
      end else begin
        bits_d  = acc[3:0] & lo_mask[3:0];
        count_d = rem[2:0];
        gp_d    = gp_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 2'd0;
      no_pad_q <= 1'b0;
      bits_q   <= 4'd0;
      count_q  <= 3'd0;
      gp_q     <= 3'd0;
    end else begin
      mode_q   <= mode_d;
      no_pad_q <= no_pad_d;
      bits_q   <= bits_d;
      count_q  <= count_d;
      gp_q     <= gp_d;
    end
  end

endmodule

>>> rtl/b3264enc_queue.sv
// ----------------------------------------------------------------------------
// b3264enc_queue: command queue between front and back
// Small FIFO of commands; head entry is read straight from its register.
// ----------------------------------------------------------------------------
module b3264enc_queue #(
  parameter int unsigned Depth = b3264enc_pkg::CmdQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b3264enc_pkg::cmd_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output b3264enc_pkg::cmd_t rdata_o
);
  import b3264enc_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  cmd_t           mem_q [Depth];
  logic [AW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = count_q == CW'(Depth);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    if (do_pop)  rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    if (do_push & ~do_pop)      count_d = count_q + 1'b1;
    else if (do_pop & ~do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

>>> rtl/b3264enc_back.sv
// ----------------------------------------------------------------------------
// b3264enc_back: output side of the encoder
// Walks the head command (characters, then '=') one character per cycle, while
// the output register is empty or being popped, into that register for the consumer.
// ----------------------------------------------------------------------------
module b3264enc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // command queue side
  input  logic                    q_empty_i,
  input  b3264enc_pkg::cmd_t      cmd_i,
  output logic                    q_pop_o,
  // result word
  output logic                    empty_o,
  input  logic                    pop_i,
  output b3264enc_pkg::out_word_t out_o
);
  import b3264enc_pkg::*;

  logic      [3:0] idx_q, idx_d;
  logic            vld_q, vld_d;
  out_word_t       out_q, out_d;
  logic      [3:0] total;
  logic            is_final, can_load, load;

  assign total    = {2'b00, cmd_i.nchar} + {1'b0, cmd_i.npad};
  assign is_final = idx_q == (total - 4'd1);
  assign can_load = ~vld_q | pop_i;
  assign load     = can_load & ~q_empty_i;
  assign q_pop_o  = load & is_final;
  assign empty_o  = ~vld_q;
  assign out_o    = out_q;

  // Next character and position within the command
  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    out_d = out_q;
    if (load) begin
      vld_d = 1'b1;
      out_d.out_char  = (idx_q < {2'b00, cmd_i.nchar}) ? cmd_i.chars[idx_q[1:0]]
                                                       : PadChar;
      out_d.last_char = cmd_i.last & is_final;
      idx_d = is_final ? 4'd0 : idx_q + 4'd1;
    end else if (pop_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

>>> rtl/base32_base64_stream_encoder.sv
// Path: the first character of a byte reaches the result ports through the queue
//   write and then the output load when the back end is idle.
// Throughput: one character per cycle from the back end while the consumer pops;
//   an ordinary byte gives 1 or 2 characters there, a last byte up to 8.
// Reset clears mode, no_pad, the packing state, the queue and the output valid.
// ----------------------------------------------------------------------------
// base32_base64_stream_encoder: RFC 4648 base32/base32hex/base64 encoder
// Front packs bytes into digits and pushes commands; back emits characters.
// ----------------------------------------------------------------------------
module base32_base64_stream_encoder #(
  parameter int unsigned CmdDepth = b3264enc_pkg::CmdQueueDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [b3264enc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [b3264enc_pkg::CfgDataW-1:0]  cfg_data_i,
  // input queue side
  input  logic                               push,
  output logic                               full,
  input  b3264enc_pkg::in_word_t             in_i,
  // result queue side
  output logic                               empty,
  input  logic                               pop,
  output b3264enc_pkg::out_word_t            out_o
);
  import b3264enc_pkg::*;

  cmd_t cmd_in, cmd_head;
  logic cmd_push, q_full, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  b3264enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  b3264enc_queue #(
    .Depth(CmdDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .rdata_o(cmd_head)
  );

  b3264enc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .cmd_i    (cmd_head),
    .q_pop_o  (q_pop),
    .empty_o  (empty),
    .pop_i    (pop),
    .out_o    (out_o)
  );

endmodule

>>> verif/tb_base32_base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// tb_base32_base64_stream_encoder: self-checking bench for the stream encoder
// Sends byte messages under all alphabets and padding settings. A predictor
// turns each accepted byte into the characters it must produce. The monitor
// then compares every popped word with the oldest predicted character.
// ----------------------------------------------------------------------------
module tb_base32_base64_stream_encoder;
  import b3264enc_pkg::*;

  // Mode register values
  localparam logic [CfgDataW-1:0] ModeB32    = 2'd0;
  localparam logic [CfgDataW-1:0] ModeB32Hex = 2'd1;
  localparam logic [CfgDataW-1:0] ModeB64    = 2'd2;
  localparam logic [CfgDataW-1:0] ModeB64Alt = 2'd3;  // bit 1 wins: still base64

  // Register indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareB = 2'd3;

  localparam int unsigned ByteTarget  = 460;
  localparam int unsigned TailBytes   = 60;     // no idling over the last bytes
  localparam int unsigned QuietCycles = 4;      // idle cycles before a cfg write
  localparam int unsigned LongHold    = 300;    // one long receiver hold-off
  localparam int unsigned CycleLimit  = 400000;

  typedef enum logic [1:0] {
    OpByte,
    OpCfg,
    OpDrain
  } plan_kind_e;

  typedef struct packed {
    plan_kind_e            kind;
    in_word_t              word;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   data;
  } plan_op_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                push = 1'b0;
  logic                full;
  in_word_t            in_word = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_word_t           out_word;

  base32_base64_stream_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .push        (push),
    .full        (full),
    .in_i        (in_word),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_word)
  );

  // Stimulus plan and predicted characters
  plan_op_t    byte_plan[$];
  out_word_t   predicted_chars[$];
  int unsigned bytes_total = 0;
  int unsigned bytes_done = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic        tail_part = 1'b0;

  // Encoder state as the block should hold it
  logic [1:0] enc_mode = ModeB32;
  logic       enc_no_pad = 1'b0;
  logic [3:0] spare_bits = '0;
  logic [2:0] spare_count = '0;
  logic [2:0] group_pos = '0;

  string alpha_b32    = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
  string alpha_b32hex = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
  string alpha_b64    =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Digit to ASCII in the current alphabet
  function automatic logic [7:0] alpha_char(logic [5:0] d);
    if (enc_mode[ModeB64Bit]) return alpha_b64[d];
    if (enc_mode[ModeHexBit]) return alpha_b32hex[d[4:0]];
    return alpha_b32[d[4:0]];
  endfunction

  // Register write as the block applies it
  task automatic apply_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    if (idx == CfgIdxMode) begin
      enc_mode    = data;
      spare_bits  = '0;
      spare_count = '0;
      group_pos   = '0;
    end else if (idx == CfgIdxNoPad) begin
      enc_no_pad = data[0];
    end
  endtask

  // Characters caused by one byte, appended to predicted_chars
  task automatic encode_byte(input in_word_t word);
    logic [11:0] acc;
    logic [5:0]  mask;
    logic [7:0]  row[0:7];
    out_word_t   ow;
    int unsigned width, grp, nbits, k;
    width = enc_mode[ModeB64Bit] ? 6 : 5;
    grp   = enc_mode[ModeB64Bit] ? 4 : 8;
    mask  = enc_mode[ModeB64Bit] ? 6'h3f : 6'h1f;
    acc   = {spare_bits, word.data_byte};
    nbits = spare_count + 8;
    k     = 0;
    while (nbits >= width && k < 8) begin
      nbits  = nbits - width;
      row[k] = alpha_char(6'(acc >> nbits) & mask);
      k++;
    end
    if (word.last_byte) begin
      // flush the partial digit, zero filled, then pad out the group
      if (nbits != 0 && k < 8) begin
        row[k] = alpha_char(6'(acc << (width - nbits)) & mask);
        k++;
      end
      while (!enc_no_pad && ((group_pos + k) % grp) != 0 && k < 8) begin
        row[k] = PadChar;
        k++;
      end
      spare_bits  = '0;
      spare_count = '0;
      group_pos   = '0;
    end else begin
      spare_bits  = 4'(acc & ((12'd1 << nbits) - 12'd1));
      spare_count = 3'(nbits);
      group_pos   = 3'((group_pos + k) % grp);
    end
    for (int unsigned i = 0; i < k; i++) begin
      ow.out_char  = row[i];
      ow.last_char = word.last_byte && (i == k - 1);
      predicted_chars.push_back(ow);
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    plan_op_t op;
    op = '0;
    op.kind = OpByte;
    op.word.data_byte = b;
    op.word.last_byte = last;
    byte_plan.push_back(op);
    bytes_total++;
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    plan_op_t op;
    op = '0;
    op.kind = OpCfg;
    op.idx  = idx;
    op.data = data;
    byte_plan.push_back(op);
  endtask

  task automatic add_drain();
    plan_op_t op;
    op = '0;
    op.kind = OpDrain;
    byte_plan.push_back(op);
  endtask

  // Clock and reset
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Driver: bytes and register writes from byte_plan
  int unsigned gap_left = 0;
  int unsigned gap_pct = 20;
  int unsigned quiet = 0;

  always @(posedge clk_i) begin
    logic nxt_push;
    logic nxt_cfg;
    nxt_push = 1'b0;
    nxt_cfg  = 1'b0;
    if (rst_ni) begin
      if (push && !full) begin
        encode_byte(in_word);
        void'(byte_plan.pop_front());
        bytes_done++;
        if (bytes_done % 64 == 0) begin
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            default: gap_pct = 35;
          endcase
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_cfg(cfg_index, cfg_data);
        void'(byte_plan.pop_front());
        quiet = 0;
      end
      if (byte_plan.size() != 0) begin
        if (byte_plan[0].kind == OpByte) begin
          if (push && full) begin
            nxt_push = 1'b1;  // keep offering the stalled word
          end else if (gap_left != 0) begin
            gap_left--;
          end else if (bytes_total - bytes_done > TailBytes &&
                       $urandom_range(0, 99) < gap_pct) begin
            gap_left = $urandom_range(0, 7);
          end else begin
            nxt_push = 1'b1;
          end
          if (nxt_push) in_word <= byte_plan[0].word;
        end else begin
          // writes and drain points wait until the block has gone quiet
          if (predicted_chars.size() == 0 && empty) quiet++;
          else quiet = 0;
          if (quiet >= QuietCycles) begin
            if (byte_plan[0].kind == OpDrain) begin
              void'(byte_plan.pop_front());
              quiet = 0;
            end else begin
              nxt_cfg = 1'b1;
              cfg_index <= byte_plan[0].idx;
              cfg_data  <= byte_plan[0].data;
            end
          end
        end
      end
    end
    push      <= nxt_push;
    cfg_valid <= nxt_cfg;
    tail_part <= (bytes_total - bytes_done) <= TailBytes;
  end

  // Monitor: pops words and checks them against predicted_chars
  int unsigned hold_left = 0;
  int unsigned stall_pct = 20;
  int unsigned chars_seen = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    logic      nxt_pop;
    out_word_t want;
    nxt_pop = 1'b0;
    if (rst_ni) begin
      if (pop && !empty) begin
        chars_seen++;
        if (chars_seen % 64 == 0) stall_pct = $urandom_range(0, 2) * 25;
        if (predicted_chars.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: char %h last %b", out_word.out_char,
                     out_word.last_char);
        end else begin
          want = predicted_chars.pop_front();
          if (want.out_char != out_word.out_char || want.last_char != out_word.last_char) begin
            errors++;
            if (errors <= 10)
              $display("word mismatch: expected char %h last %b, got char %h last %b",
                       want.out_char, want.last_char, out_word.out_char,
                       out_word.last_char);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (!long_hold_done && chars_seen >= 150 && push &&
                   predicted_chars.size() >= 2) begin
        // hold off long enough for the block to fill and stall its input
        long_hold_done = 1'b1;
        hold_left = LongHold;
      end else if (!tail_part && $urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(0, 7);
      end else begin
        nxt_pop = 1'b1;
      end
    end
    pop <= nxt_pop;
  end

  // Stimulus and end of run
  initial begin
    logic [CfgDataW-1:0] mode_pick;
    int unsigned         n_msgs, len;
    logic                abandon;

    // Base32 with padding after reset: extremes, high bit set, exact group
    add_byte(8'h00, 1'b1);
    add_byte(8'hff, 1'b1);
    add_byte(8'h80, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'hfe, 1'b0);
    add_byte(8'h55, 1'b1);
    add_byte(8'haa, 1'b0);
    add_byte(8'h55, 1'b1);

    add_cfg(CfgIdxMode, ModeB32Hex);
    add_byte(8'hff, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b1);
    add_cfg(CfgIdxNoPad, 2'd1);
    add_byte(8'h12, 1'b1);

    // Base64 without and with padding
    add_cfg(CfgIdxMode, ModeB64);
    add_byte(8'hff, 1'b0);
    add_byte(8'h80, 1'b1);
    add_cfg(CfgIdxNoPad, 2'd0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'h7f, 1'b1);
    add_byte(8'hc3, 1'b1);

    // Mode 3 selects base64 too
    add_cfg(CfgIdxMode, ModeB64Alt);
    add_byte(8'hfc, 1'b0);
    add_byte(8'h0f, 1'b1);

    // Mode write in the middle of a message drops the partial state
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b0);
    add_cfg(CfgIdxMode, ModeB32);
    add_byte(8'h43, 1'b1);

    // no_pad write mid message keeps the state; upper data bit is ignored
    add_byte(8'h9a, 1'b0);
    add_cfg(CfgIdxNoPad, 2'd1);
    add_byte(8'h3c, 1'b1);
    add_cfg(CfgIdxNoPad, 2'd2);
    add_cfg(CfgIdxSpareA, 2'd3);
    add_cfg(CfgIdxSpareB, 2'd1);
    add_byte(8'h66, 1'b1);

    // Random phases: new setting, then a few messages with random content
    while (bytes_total < ByteTarget) begin
      mode_pick = CfgDataW'($urandom_range(0, 3));
      add_cfg(CfgIdxMode, mode_pick);
      if ($urandom_range(0, 1) == 1) add_cfg(CfgIdxNoPad, CfgDataW'($urandom_range(0, 3)));
      if ($urandom_range(0, 7) == 0)
        add_cfg($urandom_range(0, 1) ? CfgIdxSpareA : CfgIdxSpareB,
                CfgDataW'($urandom_range(0, 3)));
      n_msgs = $urandom_range(2, 6);
      repeat (n_msgs) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 7);
        abandon = ($urandom_range(0, 9) == 0);
        for (int unsigned i = 0; i < len; i++)
          add_byte(8'($urandom_range(0, 255)), (i == len - 1) && !abandon);
        // a broken message is sometimes cut off by a mode write
        if (abandon && $urandom_range(0, 1) == 1) add_cfg(CfgIdxMode, mode_pick);
      end
      if ($urandom_range(0, 3) == 0) add_drain();
    end

    wait (rst_ni);
    while (byte_plan.size() != 0 || predicted_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && predicted_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
